// ===== rtl/core/srw_pkg.sv =====
// ----------------------------------------------------------------------------
// srw_pkg: shared types and constants for the sequence replay window
// Depth of the cell row, field widths, outcome codes and controller states.
// ----------------------------------------------------------------------------
package srw_pkg;

  // cell row
  localparam int WindowDepth = 256;
  localparam int OccW        = $clog2(WindowDepth + 1);

  // match reduction: cells are ORed in groups, one register level per stage
  localparam int GroupSize = 16;
  localparam int NumGroups = (WindowDepth + GroupSize - 1) / GroupSize;

  // field widths
  localparam int SeqW     = 64;
  localparam int OutcomeW = 2;
  localparam int CfgW     = 9;
  localparam int OutW     = OutcomeW + 1 + SeqW;
  localparam int OutBytesW = ((OutW + 7) / 8) * 8;

  // window arithmetic width, wide enough for the register and for the count
  localparam int WinW = (CfgW > OccW) ? CfgW : OccW;

  localparam logic [CfgW-1:0] WindowReset   = CfgW'(256);
  localparam logic [WinW-1:0] DefaultWindow = WinW'(256);
  localparam logic [WinW-1:0] DepthLimit    = WinW'(WindowDepth);

  // apb port
  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam logic REG_WINDOW_SIZE = 1'b0;  // word index of window_size

  typedef enum logic [OutcomeW-1:0] {
    OUT_ACCEPTED  = 2'd0,
    OUT_REORDERED = 2'd1,
    OUT_REPLAYED  = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_REDUCE,
    ST_DECIDE
  } state_e;

endpackage

// ===== rtl/core/sequence_replay_window.sv =====
// ----------------------------------------------------------------------------
// sequence_replay_window: anti-replay window for one sequence stream
// Classifies each sequence number against a high-water mark and a row of
// cells holding the most recent numbers.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one 64-bit sequence number per beat. m_tdata returns one
//   result beat per input beat: outcome (accepted, reordered, replayed),
//   admissible flag and the reported high-water mark.
//   The APB port holds window_size at address 0 (0 means 256, larger values
//   saturate to the cell count); write it only while no beat is in flight.
//   Each beat is compared against every occupied cell at once: the cell
//   matches are registered, then the group OR is registered, then the
//   controller decides and loads the output register. A new beat is taken
//   only once the compare, reduce and decide steps of the controller are
//   through and it is idle again.
//   The output register lets the next beat enter while a result waits; if
//   the receiver stalls, that next beat holds in the decide step and the
//   input side stops accepting until the result is taken.
//   Reset empties the window (occupancy zero), clears the mark to zero and
//   sets window_size to 256; the stored numbers need no clearing.
// ----------------------------------------------------------------------------
module sequence_replay_window
  import srw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [SeqW-1:0]      s_tdata,   // [63:0] sequence_number
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutBytesW-1:0] m_tdata,   // [1:0] outcome, [2] admissible,
                                          // [66:3] mark_reported, rest zero
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]     prdata,
  output logic                 pready
);

  state_e state_q, state_d;

  logic [SeqW-1:0]      key_q;
  logic [OccW-1:0]      occ_q, occ_d;
  logic [SeqW-1:0]      mark_q;
  logic [CfgW-1:0]      window_q;
  logic                 out_valid_q;
  logic [OutW-1:0]      out_data_q;

  logic                 in_beat;
  logic                 out_free;
  logic                 decide_go;
  logic                 hit;
  logic                 above_mark;
  logic                 first_item;
  logic                 do_push;
  outcome_e             outcome;
  logic [SeqW-1:0]      mark_rep;
  logic [WinW-1:0]      win_raw;
  logic [WinW-1:0]      win_eff;
  logic [WinW-1:0]      count_inc;

  logic [WindowDepth-1:0] cell_valid;
  logic [WindowDepth-1:0] cell_match;
  logic [SeqW-1:0]        cell_entry [WindowDepth];

  // apb register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE)) begin
      window_q <= pwdata[CfgW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW_SIZE) begin
      prdata = DataW'(window_q);
    end
  end

  // controller
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !out_valid_q || m_tready;

  always_comb begin
    state_d   = state_q;
    s_tready  = 1'b0;
    decide_go = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          decide_go = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // key held for the compare
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      key_q <= s_tdata;
    end
  end

  // occupancy thermometer for the cells
  always_comb begin
    for (int i = 0; i < WindowDepth; i++) begin
      cell_valid[i] = occ_q > OccW'(i);
    end
  end

  // row of cells, newest at the front
  for (genvar i = 0; i < WindowDepth; i++) begin : g_cell
    logic [SeqW-1:0] entry_in;
    if (i == 0) begin : g_head
      assign entry_in = key_q;
    end else begin : g_body
      assign entry_in = cell_entry[i-1];
    end
    srw_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (do_push),
      .entry_i    (entry_in),
      .valid_i    (cell_valid[i]),
      .key_i      (key_q),
      .entry_o    (cell_entry[i]),
      .match_o    (cell_match[i])
    );
  end

  srw_match_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .match_i (cell_match),
    .hit_o   (hit)
  );

  // classification
  assign first_item = (occ_q == '0);
  assign above_mark = key_q > mark_q;

  always_comb begin
    outcome  = OUT_REORDERED;
    mark_rep = mark_q;
    if (first_item) begin
      outcome = OUT_ACCEPTED;
    end else if (hit) begin
      outcome = OUT_REPLAYED;
    end else if (above_mark) begin
      outcome  = OUT_ACCEPTED;
      mark_rep = key_q;
    end
  end

  assign do_push = decide_go && (outcome != OUT_REPLAYED);

  // effective window and next occupancy
  assign win_raw   = WinW'(window_q);
  assign win_eff   = (win_raw == '0) ? DefaultWindow :
                     (win_raw > DepthLimit) ? DepthLimit : win_raw;
  assign count_inc = WinW'(occ_q) + WinW'(1);

  always_comb begin
    occ_d = occ_q;
    if (do_push) begin
      occ_d = (count_inc > win_eff) ? win_eff[OccW-1:0] : count_inc[OccW-1:0];
    end
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      mark_q <= '0;
    end else begin
      occ_q <= occ_d;
      if (decide_go && (first_item || (!hit && above_mark))) begin
        mark_q <= key_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (decide_go) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (decide_go) begin
      out_data_q <= {mark_rep, (outcome != OUT_REPLAYED), outcome};
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = OutBytesW'(out_data_q);

endmodule

// ===== rtl/core/srw_cell.sv =====
// ----------------------------------------------------------------------------
// srw_cell: one slot of the recent-number row
// Holds one stored sequence number, passes it to the older neighbor on a
// push and flags a registered match against the broadcast key.
// ----------------------------------------------------------------------------
module srw_cell
  import srw_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_en_i,
  input  logic [SeqW-1:0] entry_i,
  input  logic            valid_i,
  input  logic [SeqW-1:0] key_i,
  output logic [SeqW-1:0] entry_o,
  output logic            match_o
);

  logic [SeqW-1:0] entry_q;
  logic            match_q;
  logic            match_d;

  // stored number moves one cell older on each push
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      entry_q <= entry_i;
    end
  end

  // compare only while the slot lies inside the occupancy
  assign match_d = valid_i && (entry_q == key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ===== rtl/core/srw_match_reduce.sv =====
// ----------------------------------------------------------------------------
// srw_match_reduce: registered OR tree over the cell match flags
// First level ORs each group of cells into a register, the last level ORs
// the group registers into a single hit.
// ----------------------------------------------------------------------------
module srw_match_reduce
  import srw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [WindowDepth-1:0] match_i,
  output logic                   hit_o
);

  logic [NumGroups*GroupSize-1:0] match_pad;
  logic [NumGroups-1:0]           group_d;
  logic [NumGroups-1:0]           group_q;

  // pad the row to whole groups
  assign match_pad = (NumGroups*GroupSize)'(match_i);

  // group level
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      group_d[g] = |match_pad[g*GroupSize +: GroupSize];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
    end else begin
      group_q <= group_d;
    end
  end

  // final level
  assign hit_o = |group_q;

endmodule
